FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro builds one labeled concurrent assertion with async reset masking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WSC_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define WSC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/wsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the waypoint steering controller.
// No dependencies; imported by every module of the block.
package wsc_pkg;

	localparam int FULL_TURN     = 36000;
	localparam int TURN_WRAP_OFS = 72000;
	localparam int HALF_TURN_Q16 = 11796480;
	localparam int MIN_TURN      = 100;
	localparam int TURN_SPAN     = 200;
	localparam int TURN_WHEEL    = 45;
	localparam int SQRT_STEPS    = 32;
	localparam int ATAN_ENTRIES  = 24;

	localparam int DIST_BITS  = 24;
	localparam int SPEED_BITS = 11;
	localparam int WHEEL_BITS = 7;
	localparam int YAW_BITS   = 16;
	localparam int COUNT_BITS = 20;
	localparam int CFG_BITS   = 20;
	localparam int CFG_IDX_BITS = 3;

	localparam logic signed [SPEED_BITS-1:0] BACK_SPEED = -11'sd100;
	localparam logic [23:0] RECIP3 = 24'hAAAAAB;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_YAW_TOL   = 3'd0,
		REG_HEAD_OFS  = 3'd1,
		REG_ARRIVAL   = 3'd2,
		REG_TIMEOUT   = 3'd3,
		REG_MAX_SPEED = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_TURN    = 2'd0,
		MODE_FORWARD = 2'd1,
		MODE_REVERSE = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	typedef struct packed {
		logic load;
		logic diff;
		logic square;
		logic kick;
		logic post;
		logic head;
		logic decide;
		logic emit;
	} wsc_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} wsc_sts_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [21:0] atan_q16(input logic [4:0] idx);
		logic [21:0] v;
		unique case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/wsc_sqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle.
// Depends on wsc_pkg.
module wsc_sqrt import wsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [34:0] rem_n;
	logic [34:0] trial;

	assign rem_n = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(SQRT_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

FILE: rtl/core/wsc_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC: normalizes |dx|,|dy| and accumulates the angle in 1/65536 deg.
// Depends on wsc_pkg (arctangent table).
module wsc_cordic import wsc_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [32:0]        ax,
	input  logic [32:0]        ay,
	output logic               busy,
	output logic signed [24:0] angle
);

	localparam int IW = $clog2(CORDIC_STEPS);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_NORM = 3'b010,
		C_ROT  = 3'b100
	} cstate_t;

	cstate_t            state_q;
	logic [IW-1:0]      i_q;
	logic signed [43:0] x_q;
	logic signed [43:0] y_q;
	logic signed [24:0] z_q;
	logic signed [43:0] xs;
	logic signed [43:0] ys;
	logic signed [24:0] at;
	logic               small8;
	logic               small1;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = 25'(atan_q16(5'(i_q)));
	assign small8 = (x_q[43:32] == '0) && (y_q[43:32] == '0);
	assign small1 = (x_q[43:40] == '0) && (y_q[43:40] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						i_q     <= '0;
						state_q <= ((ax == '0) && (ay == '0)) ? C_IDLE : C_NORM;
					end
				end
				C_NORM: begin
					if (!small8 && !small1) begin
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					if (i_q == IW'(CORDIC_STEPS - 1)) begin
						state_q <= C_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == C_IDLE)) begin
			x_q <= 44'(ax);
			y_q <= 44'(ay);
			z_q <= '0;
		end else if (state_q == C_NORM) begin
			// shift both by eight while far below the target magnitude, then by one until it is reached
			if (small8) begin
				x_q <= x_q <<< 8;
				y_q <= y_q <<< 8;
			end else if (small1) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end
		end else if (state_q == C_ROT) begin
			if (!y_q[43]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign busy  = (state_q != C_IDLE);
	assign angle = z_q;

endmodule

FILE: rtl/core/wsc_ctrl.sv
`timescale 1ns / 1ps
// Tick sequencer: walks one input beat through the datapath steps.
// Depends on wsc_pkg (command and status structs).
module wsc_ctrl import wsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output wsc_cmd_t  cmd,
	input  wsc_sts_t  sts
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DIFF   = 9'b000000010,
		S_SQR    = 9'b000000100,
		S_KICK   = 9'b000001000,
		S_ITER   = 9'b000010000,
		S_POST   = 9'b000100000,
		S_HEAD   = 9'b001000000,
		S_DECIDE = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DIFF;
			S_DIFF:   state_d = S_SQR;
			S_SQR:    state_d = S_KICK;
			S_KICK:   state_d = S_ITER;
			S_ITER:   if (!sts.busy) state_d = S_POST;
			S_POST:   state_d = S_HEAD;
			S_HEAD:   state_d = S_DECIDE;
			S_DECIDE: state_d = S_EMIT;
			S_EMIT:   if (sts.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.diff   = (state_q == S_DIFF);
	assign cmd.square = (state_q == S_SQR);
	assign cmd.kick   = (state_q == S_KICK);
	assign cmd.post   = (state_q == S_POST);
	assign cmd.head   = (state_q == S_HEAD);
	assign cmd.decide = (state_q == S_DECIDE);
	assign cmd.emit   = (state_q == S_EMIT) && sts.out_free;

endmodule

FILE: rtl/core/wsc_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, goal state, distance and heading units, decision
// logic and output register. Depends on wsc_pkg, wsc_sqrt and wsc_cordic.
module wsc_dp import wsc_pkg::*; #(
	parameter int POSITION_BITS = 24,
	parameter int CORDIC_STEPS  = 16,
	parameter int SPEED_CLASSES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [CFG_BITS-1:0]            cfg_data,
	input  logic                           start_req,
	input  logic signed [POSITION_BITS-1:0] pose_x,
	input  logic signed [POSITION_BITS-1:0] pose_y,
	input  logic [YAW_BITS-1:0]            pose_yaw,
	input  logic signed [POSITION_BITS-1:0] target_x,
	input  logic signed [POSITION_BITS-1:0] target_y,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic signed [SPEED_BITS-1:0]   drive_speed,
	output logic signed [WHEEL_BITS-1:0]   wheel_angle,
	output logic [1:0]                     mode,
	output logic [DIST_BITS-1:0]           distance,
	input  wsc_cmd_t                       cmd,
	output wsc_sts_t                       sts
);

	localparam int AW     = POSITION_BITS + 1;
	localparam int CW     = $clog2(SPEED_CLASSES + 1);
	localparam int TDEPTH = SPEED_CLASSES / 2 + 1;
	localparam int TW     = $clog2(TDEPTH);

	// configuration
	logic [14:0]        tol_q;
	logic signed [15:0] ofs_q;
	logic [15:0]        arr_q;
	logic [19:0]        tmo_q;
	logic [9:0]         mxs_q;

	// state
	logic signed [POSITION_BITS-1:0] goal_x_q;
	logic signed [POSITION_BITS-1:0] goal_y_q;
	logic [15:0]                     goal_heading_q;
	logic [COUNT_BITS-1:0]           stuck_q;
	logic                            active_q;
	logic                            out_valid_q;

	// per-tick payload
	logic                            start_q;
	logic signed [POSITION_BITS-1:0] px_q;
	logic signed [POSITION_BITS-1:0] py_q;
	logic [YAW_BITS-1:0]             yaw_q;
	logic [32:0]                     ax_q;
	logic [32:0]                     ay_q;
	logic                            dx_neg_q;
	logic                            dy_neg_q;
	logic [61:0]                     sqx_q;
	logic [61:0]                     sqy_q;
	logic [DIST_BITS-1:0]            dist_q;
	logic signed [33:0]              hsum_q;
	logic [46:0]                     fprod_q;
	logic signed [SPEED_BITS-1:0]    res_speed_q;
	logic signed [WHEEL_BITS-1:0]    res_wheel_q;
	mode_t                           res_mode_q;
	logic signed [SPEED_BITS-1:0]    out_speed_q;
	logic signed [WHEEL_BITS-1:0]    out_wheel_q;
	mode_t                           out_mode_q;
	logic [DIST_BITS-1:0]            out_dist_q;

	// combinational
	logic signed [AW-1:0] dx_w;
	logic signed [AW-1:0] dy_w;
	logic [AW-1:0]        adx_w;
	logic [AW-1:0]        ady_w;
	logic                 sat_w;
	logic                 sq_busy;
	logic                 co_busy;
	logic [31:0]          root_w;
	logic signed [24:0]   z_w;
	logic [DIST_BITS-1:0] dist_w;
	logic [28:0]          dist25_w;
	logic signed [25:0]   a1_w;
	logic signed [25:0]   a_w;
	logic signed [17:0]   hs_w;
	logic signed [19:0]   hv_w;
	logic [15:0]          hd_w;
	logic [15:0]          delta_w;
	logic [19:0]          delk_w;
	logic [CW-1:0]        cls_w;
	logic [CW-1:0]        m_w;
	logic [8:0]           turn_tbl [TDEPTH];
	logic [8:0]           tsp_w;
	logic signed [18:0]   yaw_e;
	logic signed [18:0]   gh_e;
	logic                 left_w;
	logic [21:0]          fq_w;
	logic [9:0]           fwd_w;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 15'd105;
			ofs_q <= -16'sd3000;
			arr_q <= 16'd256;
			tmo_q <= 20'd150;
			mxs_q <= 10'd400;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_YAW_TOL:   tol_q <= cfg_data[14:0];
				REG_HEAD_OFS:  ofs_q <= cfg_data[15:0];
				REG_ARRIVAL:   arr_q <= cfg_data[15:0];
				REG_TIMEOUT:   tmo_q <= cfg_data[19:0];
				REG_MAX_SPEED: mxs_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// ---------------- distance and heading inputs ----------------
	assign dx_w  = AW'(goal_x_q) - AW'(px_q);
	assign dy_w  = AW'(goal_y_q) - AW'(py_q);
	assign adx_w = dx_w[AW-1] ? AW'(-dx_w) : AW'(dx_w);
	assign ady_w = dy_w[AW-1] ? AW'(-dy_w) : AW'(dy_w);
	assign sat_w = (|ax_q[32:31]) | (|ay_q[32:31]);

	wsc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.kick),
		.radicand (64'(sqx_q) + 64'(sqy_q)),
		.busy     (sq_busy),
		.root     (root_w)
	);

	wsc_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.kick),
		.ax     (ax_q),
		.ay     (ay_q),
		.busy   (co_busy),
		.angle  (z_w)
	);

	assign sts.busy     = sq_busy | co_busy;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign dist_w   = (sat_w || (|root_w[31:24])) ? '1 : root_w[23:0];
	assign dist25_w = (29'(dist_w) << 4) + (29'(dist_w) << 3) + 29'(dist_w);

	// place the CORDIC angle in its quadrant
	assign a1_w = dx_neg_q ? (26'sd11796480 - 26'(z_w)) : 26'(z_w);
	assign a_w  = dy_neg_q ? -a1_w : a1_w;

	// heading wrap into one turn
	assign hs_w = 18'(hsum_q >>> 16);
	assign hv_w = 20'(hs_w) + 20'(ofs_q) + 20'(TURN_WRAP_OFS);
	always_comb begin
		if (hv_w >= 20'(3 * FULL_TURN)) begin
			hd_w = 16'(hv_w - 20'(3 * FULL_TURN));
		end else if (hv_w >= 20'(2 * FULL_TURN)) begin
			hd_w = 16'(hv_w - 20'(2 * FULL_TURN));
		end else if (hv_w >= 20'(FULL_TURN)) begin
			hd_w = 16'(hv_w - 20'(FULL_TURN));
		end else begin
			hd_w = 16'(hv_w);
		end
	end

	// ---------------- turn decision ----------------
	assign delta_w = (goal_heading_q >= yaw_q) ? (goal_heading_q - yaw_q)
		: (yaw_q - goal_heading_q);
	assign delk_w = 20'(delta_w) * 20'(SPEED_CLASSES);

	always_comb begin
		cls_w = '0;
		for (int j = 1; j <= SPEED_CLASSES; j++) begin
			if (delk_w >= 20'(j * FULL_TURN)) begin
				cls_w = cls_w + 1'b1;
			end
		end
	end

	assign m_w = (cls_w > CW'(SPEED_CLASSES / 2)) ? (CW'(SPEED_CLASSES) - cls_w) : cls_w;

	for (genvar g = 0; g < TDEPTH; g++) begin : g_turn
		localparam int TS = MIN_TURN
			+ (2 * TURN_SPAN * g + SPEED_CLASSES - 1) / (2 * (SPEED_CLASSES - 1));
		assign turn_tbl[g] = 9'(TS);
	end

	assign tsp_w = turn_tbl[m_w[TW-1:0]];

	assign yaw_e = 19'(yaw_q);
	assign gh_e  = 19'(goal_heading_q);
	assign left_w = (yaw_e > gh_e)
		? ((19'(FULL_TURN) - yaw_e + gh_e) < (yaw_e - gh_e))
		: !((19'(FULL_TURN) - gh_e + yaw_e) < (gh_e - yaw_e));

	assign fq_w  = fprod_q[46:25];
	assign fwd_w = (fq_w > 22'(mxs_q)) ? mxs_q : fq_w[9:0];

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q       <= '0;
			goal_y_q       <= '0;
			goal_heading_q <= '0;
			stuck_q        <= '0;
			active_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.load && start_req) begin
				goal_x_q <= target_x;
				goal_y_q <= target_y;
			end
			if (cmd.head && start_q) begin
				goal_heading_q <= hd_w;
				stuck_q        <= '0;
				active_q       <= 1'b1;
			end
			if (cmd.decide && active_q) begin
				if (dist_q <= DIST_BITS'(arr_q)) begin
					active_q <= 1'b0;
				end else if ((delta_w > 16'(tol_q)) && (stuck_q >= tmo_q)) begin
					stuck_q <= '0;
				end else if (stuck_q != '1) begin
					stuck_q <= stuck_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_req;
			px_q    <= pose_x;
			py_q    <= pose_y;
			yaw_q   <= pose_yaw;
		end
		if (cmd.diff) begin
			ax_q     <= 33'(adx_w);
			ay_q     <= 33'(ady_w);
			dx_neg_q <= dx_w[AW-1];
			dy_neg_q <= dy_w[AW-1];
		end
		if (cmd.square) begin
			sqx_q <= ax_q[30:0] * ax_q[30:0];
			sqy_q <= ay_q[30:0] * ay_q[30:0];
		end
		if (cmd.post) begin
			dist_q  <= dist_w;
			hsum_q  <= 34'(a_w) * 34'sd100 + 34'sd32768;
			fprod_q <= 47'(dist25_w[28:6]) * 47'(RECIP3);
		end
		if (cmd.decide) begin
			res_speed_q <= '0;
			res_wheel_q <= '0;
			res_mode_q  <= MODE_STOP;
			if (active_q && (dist_q > DIST_BITS'(arr_q))) begin
				if (delta_w > 16'(tol_q)) begin
					if (stuck_q >= tmo_q) begin
						res_speed_q <= BACK_SPEED;
						res_mode_q  <= MODE_REVERSE;
					end else begin
						res_speed_q <= SPEED_BITS'(tsp_w);
						res_wheel_q <= left_w ? WHEEL_BITS'(TURN_WHEEL) : -WHEEL_BITS'(TURN_WHEEL);
						res_mode_q  <= MODE_TURN;
					end
				end else begin
					res_speed_q <= SPEED_BITS'(fwd_w);
					res_mode_q  <= MODE_FORWARD;
				end
			end
		end
		if (cmd.emit) begin
			out_speed_q <= res_speed_q;
			out_wheel_q <= res_wheel_q;
			out_mode_q  <= res_mode_q;
			out_dist_q  <= dist_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_speed = out_speed_q;
	assign wheel_angle = out_wheel_q;
	assign mode        = out_mode_q;
	assign distance    = out_dist_q;

endmodule

FILE: rtl/core/waypoint_steering_controller_unit.sv
`timescale 1ns / 1ps
// Waypoint steering controller, top level. Depends on wsc_pkg, wsc_ctrl, wsc_dp.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   start_req, pose_x/y, pose_yaw, target_x/y
//   out      output     out_valid / out_stall drive_speed, wheel_angle, mode, distance
//   cfg      input      cfg_wen               cfg_index, cfg_data
//
// The square root is the longest step of a tick, from input beat to result; the heading
// CORDIC (with 16 steps) runs beside it and is done no later.
// The next input beat can be taken in the cycle after the result is loaded into the
// output register, which holds it while out_stall is high; a held result delays
// the load and with it the next input beat.
// Reset is asynchronous, active low, clears goal and timer, and loads the configuration defaults.
module waypoint_steering_controller_unit import wsc_pkg::*; #(
	parameter int POSITION_BITS = 24,
	parameter int CORDIC_STEPS  = 16,
	parameter int SPEED_CLASSES = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [CFG_BITS-1:0]             cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            start_req,
	input  logic signed [POSITION_BITS-1:0] pose_x,
	input  logic signed [POSITION_BITS-1:0] pose_y,
	input  logic [YAW_BITS-1:0]             pose_yaw,
	input  logic signed [POSITION_BITS-1:0] target_x,
	input  logic signed [POSITION_BITS-1:0] target_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [SPEED_BITS-1:0]    drive_speed,
	output logic signed [WHEEL_BITS-1:0]    wheel_angle,
	output logic [1:0]                      mode,
	output logic [DIST_BITS-1:0]            distance
);

	wsc_cmd_t cmd;
	wsc_sts_t sts;

	wsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	wsc_dp #(
		.POSITION_BITS (POSITION_BITS),
		.CORDIC_STEPS  (CORDIC_STEPS),
		.SPEED_CLASSES (SPEED_CLASSES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start_req   (start_req),
		.pose_x      (pose_x),
		.pose_y      (pose_y),
		.pose_yaw    (pose_yaw),
		.target_x    (target_x),
		.target_y    (target_y),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.drive_speed (drive_speed),
		.wheel_angle (wheel_angle),
		.mode        (mode),
		.distance    (distance),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

FILE: rtl/core/wsc_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the waypoint steering controller, bound to the top level.
// Depends on wsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsc_checker import wsc_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [SPEED_BITS-1:0] drive_speed,
	input logic signed [WHEEL_BITS-1:0] wheel_angle,
	input logic [1:0]                   mode,
	input logic [DIST_BITS-1:0]         distance
);

	`WSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "out beat dropped while stalled")
	`WSC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(distance) && $stable(mode), "stalled out beat changed")
	`WSC_ASSERT_NEXT(a_one_tick, clk, arst_n, in_valid && !in_stall, in_stall, "second in beat taken during a tick")
	`WSC_ASSERT_NOW(a_reverse, clk, arst_n, out_valid && (mode == MODE_REVERSE), (drive_speed == BACK_SPEED) && (wheel_angle == '0), "bad reverse beat")
	`WSC_ASSERT_NOW(a_stop, clk, arst_n, out_valid && (mode == MODE_STOP), (drive_speed == '0) && (wheel_angle == '0), "bad stop beat")

endmodule

bind waypoint_steering_controller_unit wsc_checker u_wsc_checker (.*);
